/* hdl/touch_calibrate_and_hit_test_defines.svh */
// ---------------------------------------------------------------------------
// Touch calibrate and hit test: assertion macros
// Shorthand for the concurrent checks of the port checker.
// ---------------------------------------------------------------------------
`ifndef TOUCH_CALIBRATE_AND_HIT_TEST_DEFINES_SVH
`define TOUCH_CALIBRATE_AND_HIT_TEST_DEFINES_SVH

// same-cycle implication
`define TCAL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tcal_pkg.sv */
// ---------------------------------------------------------------------------
// Touch calibrate and hit test: shared package
// Types, register indexes, reset values and codes.
// ---------------------------------------------------------------------------
package tcal_pkg;

    // geometry defaults
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;
    localparam int RAW_BITS_DEF      = 12;

    // fixed field widths
    localparam int PRESSURE_W = 13;
    localparam int TIME_W     = 32;
    localparam int CLIENT_W   = 4;
    localparam int COEF_W     = 32;
    localparam int DEBOUNCE_W = 16;
    localparam int CODE_W     = 2;

    // Q16 rounding
    localparam int FRAC_BITS  = 16;
    localparam int ROUND_HALF = 32768;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_XX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_XY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_YX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_YY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd7;

    localparam logic signed [COEF_W-1:0] GAIN_XX_RST  = 32'sd7403;
    localparam logic signed [COEF_W-1:0] GAIN_XY_RST  = 32'sd1568;
    localparam logic signed [COEF_W-1:0] OFFSET_X_RST = -32'sd7129791;
    localparam logic signed [COEF_W-1:0] GAIN_YX_RST  = 32'sd1345;
    localparam logic signed [COEF_W-1:0] GAIN_YY_RST  = 32'sd5773;
    localparam logic signed [COEF_W-1:0] OFFSET_Y_RST = -32'sd6633925;
    localparam logic [PRESSURE_W-1:0]    PRESS_THR_RST = 13'd600;
    localparam logic [DEBOUNCE_W-1:0]    DEBOUNCE_RST  = 16'd250;

    // region codes
    localparam logic [CODE_W-1:0] REGION_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] REGION_FIRST  = 2'd1;
    localparam logic [CODE_W-1:0] REGION_SECOND = 2'd2;
    localparam logic [CODE_W-1:0] REGION_SEND   = 2'd3;

    // selection codes
    localparam logic [CODE_W-1:0] SEL_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] SEL_FIRST  = 2'd1;
    localparam logic [CODE_W-1:0] SEL_SECOND = 2'd2;

    // request codes
    localparam logic [CODE_W-1:0] REQ_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] REQ_FIRST  = 2'd1;
    localparam logic [CODE_W-1:0] REQ_SECOND = 2'd2;

    typedef struct packed {
        logic signed [COEF_W-1:0] gain_xx;
        logic signed [COEF_W-1:0] gain_xy;
        logic signed [COEF_W-1:0] offset_x;
        logic signed [COEF_W-1:0] gain_yx;
        logic signed [COEF_W-1:0] gain_yy;
        logic signed [COEF_W-1:0] offset_y;
        logic [PRESSURE_W-1:0]    pressure_threshold;
        logic [DEBOUNCE_W-1:0]    debounce_ms;
    } tcal_cfg_t;

    // fields that ride along the transform pipeline untouched
    typedef struct packed {
        logic                  touch_present;
        logic [PRESSURE_W-1:0] pressure;
        logic [TIME_W-1:0]     time_ms;
        logic [CLIENT_W-1:0]   client_count;
    } tcal_side_t;

    typedef struct packed {
        logic load_prod;
        logic load_coord;
    } tcal_affine_ctrl_t;

    typedef struct packed {
        logic item_valid;
        logic advance;
    } tcal_hit_ctrl_t;

    typedef struct packed {
        logic [CODE_W-1:0] region_hit;
        logic [CODE_W-1:0] selection;
        logic [CODE_W-1:0] send_request;
        logic              no_clients;
    } tcal_flags_t;

endpackage

/* hdl/tcal_affine.sv */
// ---------------------------------------------------------------------------
// Touch calibrate: affine transform
// Q16 products, then sum, round half away from zero and clamp to screen.
// ---------------------------------------------------------------------------
module tcal_affine #(
    parameter int SCREEN_WIDTH  = tcal_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tcal_pkg::SCREEN_HEIGHT_DEF,
    parameter int RAW_BITS      = tcal_pkg::RAW_BITS_DEF,
    localparam int X_W = $clog2(SCREEN_WIDTH),
    localparam int Y_W = $clog2(SCREEN_HEIGHT)
) (
    input  logic                        aclk,
    input  tcal_pkg::tcal_affine_ctrl_t ctrl,
    input  tcal_pkg::tcal_cfg_t         cfg,
    input  logic [RAW_BITS-1:0]         raw_x,
    input  logic [RAW_BITS-1:0]         raw_y,
    input  tcal_pkg::tcal_side_t        side_in,
    output logic [X_W-1:0]              pix_x,
    output logic [Y_W-1:0]              pix_y,
    output tcal_pkg::tcal_side_t        side_out
);

    localparam int PROD_W = tcal_pkg::COEF_W + RAW_BITS + 1;
    localparam int ACC_W  = PROD_W + 2;
    localparam int Q_W    = ACC_W - tcal_pkg::FRAC_BITS;

    logic signed [PROD_W-1:0] p_xx_reg, p_xy_reg, p_yx_reg, p_yy_reg;
    logic signed [PROD_W-1:0] p_xx_next, p_xy_next, p_yx_next, p_yy_next;
    tcal_pkg::tcal_side_t     side_prod_reg;

    logic signed [ACC_W-1:0]  acc_x, acc_y, rnd_x, rnd_y;
    logic [Q_W-1:0]           q_x, q_y;
    logic [X_W-1:0]           x_reg, x_next;
    logic [Y_W-1:0]           y_reg, y_next;
    tcal_pkg::tcal_side_t     side_coord_reg;

    // stage 1: four 32 x raw products
    assign p_xx_next = $signed(cfg.gain_xx) * $signed({1'b0, raw_x});
    assign p_xy_next = $signed(cfg.gain_xy) * $signed({1'b0, raw_y});
    assign p_yx_next = $signed(cfg.gain_yx) * $signed({1'b0, raw_x});
    assign p_yy_next = $signed(cfg.gain_yy) * $signed({1'b0, raw_y});

    always_ff @(posedge aclk) begin
        if (ctrl.load_prod) begin
            p_xx_reg      <= p_xx_next;
            p_xy_reg      <= p_xy_next;
            p_yx_reg      <= p_yx_next;
            p_yy_reg      <= p_yy_next;
            side_prod_reg <= side_in;
        end
    end

    // stage 2: sum, round, clamp. A negative sum always clamps to zero.
    always_comb begin
        acc_x = ACC_W'(p_xx_reg) + ACC_W'(p_xy_reg) + ACC_W'($signed(cfg.offset_x));
        acc_y = ACC_W'(p_yx_reg) + ACC_W'(p_yy_reg) + ACC_W'($signed(cfg.offset_y));
        rnd_x = acc_x + ACC_W'(tcal_pkg::ROUND_HALF);
        rnd_y = acc_y + ACC_W'(tcal_pkg::ROUND_HALF);
        q_x   = rnd_x[ACC_W-1:tcal_pkg::FRAC_BITS];
        q_y   = rnd_y[ACC_W-1:tcal_pkg::FRAC_BITS];

        if (acc_x[ACC_W-1]) begin
            x_next = '0;
        end else if (q_x > Q_W'(SCREEN_WIDTH - 1)) begin
            x_next = X_W'(SCREEN_WIDTH - 1);
        end else begin
            x_next = q_x[X_W-1:0];
        end

        if (acc_y[ACC_W-1]) begin
            y_next = '0;
        end else if (q_y > Q_W'(SCREEN_HEIGHT - 1)) begin
            y_next = Y_W'(SCREEN_HEIGHT - 1);
        end else begin
            y_next = q_y[Y_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_coord) begin
            x_reg          <= x_next;
            y_reg          <= y_next;
            side_coord_reg <= side_prod_reg;
        end
    end

    assign pix_x    = x_reg;
    assign pix_y    = y_reg;
    assign side_out = side_coord_reg;

endmodule

/* hdl/tcal_hit.sv */
// ---------------------------------------------------------------------------
// Touch calibrate: sample gate and hit test
// Debounce/pressure gate, box test, radio selection and send logic.
// ---------------------------------------------------------------------------
module tcal_hit #(
    parameter int SCREEN_WIDTH  = tcal_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tcal_pkg::SCREEN_HEIGHT_DEF,
    localparam int X_W = $clog2(SCREEN_WIDTH),
    localparam int Y_W = $clog2(SCREEN_HEIGHT)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tcal_pkg::tcal_hit_ctrl_t ctrl,
    input  tcal_pkg::tcal_cfg_t      cfg,
    input  logic [X_W-1:0]           pix_x,
    input  logic [Y_W-1:0]           pix_y,
    input  tcal_pkg::tcal_side_t     side,
    output logic                     res_accepted,
    output logic [X_W-1:0]           res_x,
    output logic [Y_W-1:0]           res_y,
    output tcal_pkg::tcal_flags_t    res_flags
);

    localparam int C_W = 16;

    typedef struct packed {
        logic [C_W-1:0] x0;
        logic [C_W-1:0] y0;
        logic [C_W-1:0] x1;
        logic [C_W-1:0] y1;
    } box_t;

    // inclusive corners
    localparam box_t BOX_FIRST  = '{x0: 16'd30,  y0: 16'd70,  x1: 16'd140, y1: 16'd160};
    localparam box_t BOX_SECOND = '{x0: 16'd180, y0: 16'd70,  x1: 16'd290, y1: 16'd160};
    localparam box_t BOX_SEND   = '{x0: 16'd70,  y0: 16'd175, x1: 16'd250, y1: 16'd235};

    function automatic logic in_box(logic [C_W-1:0] px, logic [C_W-1:0] py, box_t b);
        return (px >= b.x0) && (px <= b.x1) && (py >= b.y0) && (py <= b.y1);
    endfunction

    logic [tcal_pkg::TIME_W-1:0] last_time_reg;
    logic [tcal_pkg::CODE_W-1:0] sel_reg, sel_next;
    logic [tcal_pkg::TIME_W-1:0] gap;
    logic                        accept, commit;
    logic [C_W-1:0]              xe, ye;
    tcal_pkg::tcal_flags_t       flags_next;

    assign commit = ctrl.item_valid && ctrl.advance;
    assign gap    = side.time_ms - last_time_reg;
    assign accept = side.touch_present
                 && (gap >= tcal_pkg::TIME_W'(cfg.debounce_ms))
                 && (side.pressure >= cfg.pressure_threshold);
    assign xe = C_W'(pix_x);
    assign ye = C_W'(pix_y);

    always_comb begin
        sel_next                = sel_reg;
        flags_next.region_hit   = tcal_pkg::REGION_NONE;
        flags_next.send_request = tcal_pkg::REQ_NONE;
        flags_next.no_clients   = 1'b0;
        if (accept) begin
            if (in_box(xe, ye, BOX_FIRST)) begin
                flags_next.region_hit = tcal_pkg::REGION_FIRST;
                sel_next = (sel_reg == tcal_pkg::SEL_FIRST) ? tcal_pkg::SEL_NONE
                                                            : tcal_pkg::SEL_FIRST;
            end else if (in_box(xe, ye, BOX_SECOND)) begin
                flags_next.region_hit = tcal_pkg::REGION_SECOND;
                sel_next = (sel_reg == tcal_pkg::SEL_SECOND) ? tcal_pkg::SEL_NONE
                                                             : tcal_pkg::SEL_SECOND;
            end else if (in_box(xe, ye, BOX_SEND)) begin
                flags_next.region_hit = tcal_pkg::REGION_SEND;
                if (sel_reg != tcal_pkg::SEL_NONE) begin
                    if (side.client_count == '0) begin
                        flags_next.no_clients = 1'b1;
                    end else begin
                        flags_next.send_request = (sel_reg == tcal_pkg::SEL_FIRST)
                                                ? tcal_pkg::REQ_FIRST
                                                : tcal_pkg::REQ_SECOND;
                        sel_next = tcal_pkg::SEL_NONE;
                    end
                end
            end
        end
        flags_next.selection = sel_next;
    end

    // state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            sel_reg       <= tcal_pkg::SEL_NONE;
        end else if (commit) begin
            sel_reg <= sel_next;
            if (accept) begin
                last_time_reg <= side.time_ms;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (commit) begin
            res_accepted <= accept;
            res_x        <= accept ? pix_x : '0;
            res_y        <= accept ? pix_y : '0;
            res_flags    <= flags_next;
        end
    end

endmodule

/* hdl/touch_calibrate_and_hit_test.sv */
// ---------------------------------------------------------------------------
// Touch calibrate and hit test
// Gates raw touch samples, maps them to the screen and tests the buttons.
// ---------------------------------------------------------------------------
//
//  channel   | direction | carries
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | one raw touch sample per item
//  m_axis    | out       | one result item per sample, in order
//  cfg       | in        | register writes, taken at once, no read-back
//
//  One item per cycle sustained while m_tready is high: every stage takes a new
//  item on each cycle it advances. Four registers (input, product, coordinate,
//  result) lie between an accepted item and m_tvalid. The product stage (four
//  32 x RAW_BITS multiplies) sets the critical path.
//  Reset (aresetn, synchronous, low) empties the pipe, clears selection and
//  last accepted time and reloads the calibration defaults; no clearing pass.
//  Each stage holds only while the one after it is full and held, so with
//  m_tready low the block keeps taking items until all stages are full.
//
module touch_calibrate_and_hit_test #(
    parameter int SCREEN_WIDTH  = tcal_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tcal_pkg::SCREEN_HEIGHT_DEF,
    parameter int RAW_BITS      = tcal_pkg::RAW_BITS_DEF,
    localparam int X_W          = $clog2(SCREEN_WIDTH),
    localparam int Y_W          = $clog2(SCREEN_HEIGHT),
    localparam int S_FIELDS_W   = 1 + 2 * RAW_BITS + tcal_pkg::PRESSURE_W
                                + tcal_pkg::TIME_W + tcal_pkg::CLIENT_W,
    localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8,
    localparam int M_FIELDS_W   = 1 + X_W + Y_W + 3 * tcal_pkg::CODE_W + 1,
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // touch_present, raw_x, raw_y, pressure, time_ms, client_count
    input  logic [S_TDATA_W-1:0]            s_tdata,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // accepted, pix_x, pix_y, region_hit, selection, send_request,
    // no_clients
    output logic [M_TDATA_W-1:0]            m_tdata,

    input  logic                            cfg_wr_en,
    input  logic [tcal_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcal_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // input field positions
    localparam int RX_LSB = 1;
    localparam int RY_LSB = RX_LSB + RAW_BITS;
    localparam int PR_LSB = RY_LSB + RAW_BITS;
    localparam int TM_LSB = PR_LSB + tcal_pkg::PRESSURE_W;
    localparam int CC_LSB = TM_LSB + tcal_pkg::TIME_W;

    // configuration registers
    tcal_pkg::tcal_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_xx            <= tcal_pkg::GAIN_XX_RST;
            cfg_reg.gain_xy            <= tcal_pkg::GAIN_XY_RST;
            cfg_reg.offset_x           <= tcal_pkg::OFFSET_X_RST;
            cfg_reg.gain_yx            <= tcal_pkg::GAIN_YX_RST;
            cfg_reg.gain_yy            <= tcal_pkg::GAIN_YY_RST;
            cfg_reg.offset_y           <= tcal_pkg::OFFSET_Y_RST;
            cfg_reg.pressure_threshold <= tcal_pkg::PRESS_THR_RST;
            cfg_reg.debounce_ms        <= tcal_pkg::DEBOUNCE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tcal_pkg::CFG_GAIN_XX:   cfg_reg.gain_xx  <= cfg_wdata;
                tcal_pkg::CFG_GAIN_XY:   cfg_reg.gain_xy  <= cfg_wdata;
                tcal_pkg::CFG_OFFSET_X:  cfg_reg.offset_x <= cfg_wdata;
                tcal_pkg::CFG_GAIN_YX:   cfg_reg.gain_yx  <= cfg_wdata;
                tcal_pkg::CFG_GAIN_YY:   cfg_reg.gain_yy  <= cfg_wdata;
                tcal_pkg::CFG_OFFSET_Y:  cfg_reg.offset_y <= cfg_wdata;
                tcal_pkg::CFG_PRESS_THR: begin
                    cfg_reg.pressure_threshold <= cfg_wdata[tcal_pkg::PRESSURE_W-1:0];
                end
                tcal_pkg::CFG_DEBOUNCE: begin
                    cfg_reg.debounce_ms <= cfg_wdata[tcal_pkg::DEBOUNCE_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // pipeline occupancy and per-stage advance
    logic in_valid_reg, prod_valid_reg, coord_valid_reg, out_valid_reg;
    logic adv_in, adv_prod, adv_coord, adv_out;

    assign adv_out   = !out_valid_reg   || m_tready;
    assign adv_coord = !coord_valid_reg || adv_out;
    assign adv_prod  = !prod_valid_reg  || adv_coord;
    assign adv_in    = !in_valid_reg    || adv_prod;
    assign s_tready  = adv_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            prod_valid_reg  <= 1'b0;
            coord_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (adv_in)    in_valid_reg    <= s_tvalid;
            if (adv_prod)  prod_valid_reg  <= in_valid_reg;
            if (adv_coord) coord_valid_reg <= prod_valid_reg;
            if (adv_out)   out_valid_reg   <= coord_valid_reg;
        end
    end

    // input register
    logic [RAW_BITS-1:0]  raw_x_reg, raw_y_reg;
    tcal_pkg::tcal_side_t side_in_reg;

    always_ff @(posedge aclk) begin
        if (adv_in) begin
            raw_x_reg                <= s_tdata[RX_LSB +: RAW_BITS];
            raw_y_reg                <= s_tdata[RY_LSB +: RAW_BITS];
            side_in_reg.touch_present <= s_tdata[0];
            side_in_reg.pressure     <= s_tdata[PR_LSB +: tcal_pkg::PRESSURE_W];
            side_in_reg.time_ms      <= s_tdata[TM_LSB +: tcal_pkg::TIME_W];
            side_in_reg.client_count <= s_tdata[CC_LSB +: tcal_pkg::CLIENT_W];
        end
    end

    // affine transform: products, then round and clamp
    tcal_pkg::tcal_affine_ctrl_t affine_ctrl;
    logic [X_W-1:0]              coord_x;
    logic [Y_W-1:0]              coord_y;
    tcal_pkg::tcal_side_t        side_coord;

    assign affine_ctrl.load_prod  = adv_prod;
    assign affine_ctrl.load_coord = adv_coord;

    tcal_affine #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .RAW_BITS     (RAW_BITS)
    ) u_affine (
        .aclk    (aclk),
        .ctrl    (affine_ctrl),
        .cfg     (cfg_reg),
        .raw_x   (raw_x_reg),
        .raw_y   (raw_y_reg),
        .side_in (side_in_reg),
        .pix_x   (coord_x),
        .pix_y   (coord_y),
        .side_out(side_coord)
    );

    // gate, hit test and selection state; holds the result register
    tcal_pkg::tcal_hit_ctrl_t hit_ctrl;
    logic                     res_accepted;
    logic [X_W-1:0]           res_x;
    logic [Y_W-1:0]           res_y;
    tcal_pkg::tcal_flags_t    res_flags;

    assign hit_ctrl.item_valid = coord_valid_reg;
    assign hit_ctrl.advance    = adv_out;

    tcal_hit #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_hit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (hit_ctrl),
        .cfg         (cfg_reg),
        .pix_x       (coord_x),
        .pix_y       (coord_y),
        .side        (side_coord),
        .res_accepted(res_accepted),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_flags   (res_flags)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({res_flags.no_clients, res_flags.send_request,
                                  res_flags.selection, res_flags.region_hit,
                                  res_y, res_x, res_accepted});

endmodule

/* hdl/tcal_checker.sv */
// ---------------------------------------------------------------------------
// Touch calibrate and hit test: port checker
// Watches the result channel for consistency between fields and over time.
// ---------------------------------------------------------------------------
`include "touch_calibrate_and_hit_test_defines.svh"

module tcal_checker #(
    parameter int SCREEN_WIDTH  = tcal_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tcal_pkg::SCREEN_HEIGHT_DEF,
    localparam int X_W          = $clog2(SCREEN_WIDTH),
    localparam int Y_W          = $clog2(SCREEN_HEIGHT),
    localparam int M_FIELDS_W   = 1 + X_W + Y_W + 3 * tcal_pkg::CODE_W + 1,
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    localparam int X_LSB   = 1;
    localparam int Y_LSB   = X_LSB + X_W;
    localparam int RG_LSB  = Y_LSB + Y_W;
    localparam int SEL_LSB = RG_LSB + tcal_pkg::CODE_W;
    localparam int REQ_LSB = SEL_LSB + tcal_pkg::CODE_W;
    localparam int NOC_BIT = REQ_LSB + tcal_pkg::CODE_W;

    logic [tcal_pkg::CODE_W-1:0] region, sel, req;

    assign region = m_tdata[RG_LSB +: tcal_pkg::CODE_W];
    assign sel    = m_tdata[SEL_LSB +: tcal_pkg::CODE_W];
    assign req    = m_tdata[REQ_LSB +: tcal_pkg::CODE_W];

    // a rejected sample carries nothing but the selection
    `TCAL_ASSERT_NOW(a_reject_clear, aclk, aresetn, m_tvalid && !m_tdata[0], (m_tdata[X_LSB +: X_W] == '0) && (m_tdata[Y_LSB +: Y_W] == '0) && (region == tcal_pkg::REGION_NONE) && (req == tcal_pkg::REQ_NONE) && !m_tdata[NOC_BIT], "rejected sample with non-zero fields")

    // a request only from the send box, and it clears the selection
    `TCAL_ASSERT_NOW(a_send_clears, aclk, aresetn, m_tvalid && (req != tcal_pkg::REQ_NONE), (region == tcal_pkg::REGION_SEND) && (sel == tcal_pkg::SEL_NONE) && !m_tdata[NOC_BIT], "request without send box or with selection kept")

    // no-clients flag keeps the selection and sends nothing
    `TCAL_ASSERT_NOW(a_no_clients, aclk, aresetn, m_tvalid && m_tdata[NOC_BIT], (region == tcal_pkg::REGION_SEND) && (sel != tcal_pkg::SEL_NONE) && (req == tcal_pkg::REQ_NONE), "no-clients flag inconsistent")

    // clamped point lies on the screen
    `TCAL_ASSERT_NOW(a_on_screen, aclk, aresetn, m_tvalid, (m_tdata[X_LSB +: X_W] <= X_W'(SCREEN_WIDTH - 1)) && (m_tdata[Y_LSB +: Y_W] <= Y_W'(SCREEN_HEIGHT - 1)), "point off screen")

    // a stalled result holds
    `TCAL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

endmodule

bind touch_calibrate_and_hit_test tcal_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_tcal_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Touch calibrate and hit test: self-checking testbench
// Sends raw touch samples through the stream port, predicts each untyped result
// item from a behavioural copy of the gating, Q16 mapping and button logic,
// and checks the result stream in order under random back-pressure.
// ---------------------------------------------------------------------------
module testbench;
    import tcal_pkg::*;

    localparam int S_W = 80;
    localparam int M_W = 32;

    // screen limits and the three buttons (inclusive edges)
    localparam int X_MAX    = 319;
    localparam int Y_MAX    = 239;
    localparam int FIRST_X  = 30;
    localparam int SECOND_X = 180;
    localparam int OPT_Y    = 70;
    localparam int OPT_W    = 110;
    localparam int OPT_H    = 90;
    localparam int SEND_X   = 70;
    localparam int SEND_Y   = 175;
    localparam int SEND_W   = 180;
    localparam int SEND_H   = 60;

    // packed lowest field last, so the struct matches the tdata layout
    typedef struct packed {
        logic [CLIENT_W-1:0]   clients;
        logic [TIME_W-1:0]     time_ms;
        logic [PRESSURE_W-1:0] pressure;
        logic [11:0]           raw_y;
        logic [11:0]           raw_x;
        logic                  present;
    } touch_sample_t;

    typedef struct packed {
        logic              no_clients;
        logic [CODE_W-1:0] request;
        logic [CODE_W-1:0] selection;
        logic [CODE_W-1:0] region;
        logic [7:0]        pix_y;
        logic [8:0]        pix_x;
        logic              accepted;
    } touch_result_t;

    typedef struct packed {
        bit            typed;
        touch_result_t res;
        touch_sample_t smp;
    } table_row_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [M_W-1:0]   m_tdata;
    logic             cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // predictor state: calibration copy, last accepted time, radio selection
    tcal_cfg_t         cal;
    logic [31:0]       last_touch_ms;
    logic [CODE_W-1:0] radio_sel;

    logic [31:0]       now_ms;
    touch_result_t     pending_results[$];
    table_row_t        directed_rows[$];
    logic [31:0]       phase_cal[5][8];
    int                phase_items[5] = '{250, 250, 150, 250, 220};
    int                mismatch_count = 0;
    int                send_idle_pct  = 7;
    int                recv_stall_pct = 46;

    touch_calibrate_and_hit_test dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Q16 -> pixel: round half away from zero, then clamp to [0, hi]
    function automatic int to_pixel(input longint acc, input int hi);
        longint q;
        q = (((acc < 0) ? -acc : acc) + longint'(ROUND_HALF)) >>> FRAC_BITS;
        if (acc < 0) q = -q;
        if (q < 0) q = 0;
        else if (q > hi) q = hi;
        return int'(q);
    endfunction

    function automatic bit hit_box(input int x, input int y, input int x0, input int y0,
                                   input int w, input int h);
        return x >= x0 && x <= x0 + w && y >= y0 && y <= y0 + h;
    endfunction

    // Gate, map and hit-test one sample; advances the predictor state.
    function automatic touch_result_t calibrate_and_hit(input touch_sample_t smp);
        touch_result_t r;
        logic [31:0]   elapsed;
        longint        acc_x, acc_y;
        int            px, py;
        r = '0;
        elapsed = smp.time_ms - last_touch_ms;     // wraps like the timestamp
        if (smp.present && elapsed >= 32'(cal.debounce_ms) &&
            smp.pressure >= cal.pressure_threshold) begin
            acc_x = longint'($signed(cal.gain_xx)) * longint'(smp.raw_x)
                  + longint'($signed(cal.gain_xy)) * longint'(smp.raw_y)
                  + longint'($signed(cal.offset_x));
            acc_y = longint'($signed(cal.gain_yx)) * longint'(smp.raw_x)
                  + longint'($signed(cal.gain_yy)) * longint'(smp.raw_y)
                  + longint'($signed(cal.offset_y));
            px = to_pixel(acc_x, X_MAX);
            py = to_pixel(acc_y, Y_MAX);
            r.accepted = 1'b1;
            r.pix_x    = px[8:0];
            r.pix_y    = py[7:0];
            // first match wins; option boxes toggle
            if (hit_box(px, py, FIRST_X, OPT_Y, OPT_W, OPT_H)) begin
                r.region  = REGION_FIRST;
                radio_sel = (radio_sel == SEL_FIRST) ? SEL_NONE : SEL_FIRST;
            end else if (hit_box(px, py, SECOND_X, OPT_Y, OPT_W, OPT_H)) begin
                r.region  = REGION_SECOND;
                radio_sel = (radio_sel == SEL_SECOND) ? SEL_NONE : SEL_SECOND;
            end else if (hit_box(px, py, SEND_X, SEND_Y, SEND_W, SEND_H)) begin
                r.region = REGION_SEND;
                // nothing selected: nothing sent, no flag
                if (radio_sel != SEL_NONE) begin
                    if (smp.clients == '0) begin
                        r.no_clients = 1'b1;      // selection kept
                    end else begin
                        r.request = (radio_sel == SEL_FIRST) ? REQ_FIRST : REQ_SECOND;
                        radio_sel = SEL_NONE;
                    end
                end
            end
            last_touch_ms = smp.time_ms;
        end
        r.selection = radio_sel;
        return r;
    endfunction

    // Random sample: mostly well spaced, hard enough presses; some noise.
    function automatic touch_sample_t random_touch();
        touch_sample_t smp;
        int            pick;
        smp.present = ($urandom_range(0, 9) != 0);
        smp.raw_x   = 12'($urandom);
        smp.raw_y   = 12'($urandom);
        pick = int'($urandom_range(0, 99));
        if (pick < 5)
            now_ms = $urandom;                            // jump, may go back
        else if (pick < 20)
            now_ms = now_ms + $urandom_range(0, cal.debounce_ms);
        else
            now_ms = now_ms + 32'(cal.debounce_ms) + $urandom_range(0, 300);
        smp.time_ms  = now_ms;
        smp.pressure = ($urandom_range(0, 99) < 15) ? 13'($urandom)
                     : 13'($urandom_range(cal.pressure_threshold, 8191));
        smp.clients  = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
        return smp;
    endfunction

    // Typed rows only ever expect nothing selected.
    function automatic void add_row(input logic p, input int rx, input int ry, input int pr,
                                    input logic [31:0] t, input int c, input bit typed,
                                    input int acc, input int sx, input int sy);
        table_row_t row;
        row = '0;
        row.smp.present  = p;
        row.smp.raw_x    = 12'(rx);
        row.smp.raw_y    = 12'(ry);
        row.smp.pressure = 13'(pr);
        row.smp.time_ms  = t;
        row.smp.clients  = 4'(c);
        row.typed        = typed;
        row.res.accepted = acc[0];
        row.res.pix_x    = 9'(sx);
        row.res.pix_y    = 8'(sy);
        row.res.region   = REGION_NONE;
        row.res.selection = SEL_NONE;
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // One item onto the input stream; expectation recorded at acceptance.
    // Each cycle before the item the sender idles with send_idle_pct chance.
    task automatic send_touch(input touch_sample_t smp, input bit typed,
                              input touch_result_t typed_res);
        touch_result_t predicted;
        @(negedge aclk);
        while (int'($urandom_range(0, 99)) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, smp};
        do @(posedge aclk); while (!s_tready);
        predicted = calibrate_and_hit(smp);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // every result in, then let the pipe settle (four stages)
    task automatic drain();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apply_calibration(input logic [31:0] vals[8]);
        int i;
        for (i = 0; i < 8; i++) begin
            @(negedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            case (CFG_IDX_W'(i))
                CFG_GAIN_XX:   cal.gain_xx  = vals[i];
                CFG_GAIN_XY:   cal.gain_xy  = vals[i];
                CFG_OFFSET_X:  cal.offset_x = vals[i];
                CFG_GAIN_YX:   cal.gain_yx  = vals[i];
                CFG_GAIN_YY:   cal.gain_yy  = vals[i];
                CFG_OFFSET_Y:  cal.offset_y = vals[i];
                CFG_PRESS_THR: cal.pressure_threshold = vals[i][PRESSURE_W-1:0];
                CFG_DEBOUNCE:  cal.debounce_ms = vals[i][DEBOUNCE_W-1:0];
                default: ;
            endcase
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: random back-pressure, changes on the falling edge.
    initial begin : result_sink
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
        end
    end

    // In-order check of every result item against the oldest expectation.
    always @(posedge aclk) begin : result_check
        touch_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[24:0];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result item with nothing expected, actual %h", $time, got);
            end else begin
                want = pending_results.pop_front();
                check_field("accepted",   32'(want.accepted),   32'(got.accepted));
                check_field("pix_x",      32'(want.pix_x),      32'(got.pix_x));
                check_field("pix_y",      32'(want.pix_y),      32'(got.pix_y));
                check_field("region_hit", 32'(want.region),     32'(got.region));
                check_field("selection",  32'(want.selection),  32'(got.selection));
                check_field("send_req",   32'(want.request),    32'(got.request));
                check_field("no_clients", 32'(want.no_clients), 32'(got.no_clients));
            end
        end
    end

    initial begin : stimulus
        int p, k;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;

        cal = '{gain_xx: GAIN_XX_RST, gain_xy: GAIN_XY_RST, offset_x: OFFSET_X_RST,
                gain_yx: GAIN_YX_RST, gain_yy: GAIN_YY_RST, offset_y: OFFSET_Y_RST,
                pressure_threshold: PRESS_THR_RST, debounce_ms: DEBOUNCE_RST};
        last_touch_ms = '0;
        radio_sel     = SEL_NONE;

        // linear map onto the whole screen, every touching sample gets through
        phase_cal[1] = '{32'd5120, 32'd0, 32'd0, 32'd0, 32'd3840, 32'd0, 32'd0, 32'd0};
        // extreme gains and offsets, hardest press, longest debounce
        phase_cal[2] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'd8191, 32'd65535};
        // mirrored map with half-pixel offsets: exact ties on many raw values
        phase_cal[3] = '{32'hFFFF_EC00, 32'd0, 32'h0140_8000, 32'd0,
                         32'hFFFF_F100, 32'h00EF_8000, 32'd1234, 32'd1};
        // reset geometry again, other gating
        phase_cal[4] = '{GAIN_XX_RST, GAIN_XY_RST, OFFSET_X_RST, GAIN_YX_RST,
                         GAIN_YY_RST, OFFSET_Y_RST, 32'd300, 32'd100};

        // Directed part, reset calibration. Aim points: first box (1258,2162),
        // second box (2655,1836), send box (1728,3074).
        //       pres  rx    ry    press  time           cl typed acc sx   sy
        add_row(1'b1, 0,    0,    600,   32'd100,        1, 1,   0,  0,   0);   // too early after reset
        add_row(1'b1, 0,    0,    600,   32'd250,        1, 1,   1,  0,   0);   // debounce and threshold met exactly
        add_row(1'b1, 0,    0,    8191,  32'd499,        1, 1,   0,  0,   0);   // one ms short
        add_row(1'b1, 0,    0,    599,   32'd500,        1, 1,   0,  0,   0);   // too light
        add_row(1'b0, 4095, 4095, 8191,  32'd500,        15, 1,  0,  0,   0);   // no touch
        add_row(1'b1, 4095, 4095, 8191,  32'd500,        15, 1,  1,  319, 239); // clamped corner
        add_row(1'b1, 1728, 3074, 700,   32'd750,        5, 0,   0,  0,   0);   // send, nothing selected
        add_row(1'b1, 1258, 2162, 700,   32'd1000,       5, 0,   0,  0,   0);
        add_row(1'b1, 1258, 2162, 700,   32'd1250,       5, 0,   0,  0,   0);   // toggles off
        add_row(1'b1, 1258, 2162, 700,   32'd1500,       5, 0,   0,  0,   0);
        add_row(1'b1, 2655, 1836, 700,   32'd1750,       5, 0,   0,  0,   0);   // radio switch
        add_row(1'b1, 1728, 3074, 700,   32'd2000,       0, 0,   0,  0,   0);   // send, no clients
        add_row(1'b1, 1728, 3074, 700,   32'd2250,       15, 0,  0,  0,   0);   // send second
        add_row(1'b1, 1258, 2162, 700,   32'd2500,       3, 0,   0,  0,   0);
        add_row(1'b1, 1728, 3074, 700,   32'd2750,       1, 0,   0,  0,   0);   // send first
        add_row(1'b1, 0,    0,    4000,  32'hFFFF_FF00,  0, 1,   1,  0,   0);
        add_row(1'b1, 0,    0,    4000,  32'h0000_0000,  0, 1,   1,  0,   0);   // timestamp wraps
        add_row(1'b1, 0,    0,    4000,  32'd249,        0, 1,   0,  0,   0);
        add_row(1'b1, 0,    0,    0,     32'h8000_0000,  0, 1,   0,  0,   0);
        add_row(1'b0, 0,    0,    0,     32'h8000_0000,  0, 1,   0,  0,   0);
        add_row(1'b1, 4095, 0,    8191,  32'h9000_0000,  9, 0,   0,  0,   0);
        add_row(1'b1, 0,    4095, 8191,  32'hA000_0000,  9, 0,   0,  0,   0);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < directed_rows.size(); k++)
            send_touch(directed_rows[k].smp, directed_rows[k].typed, directed_rows[k].res);
        now_ms = 32'hA000_0000;

        // random phases; config only written with the pipe empty
        for (p = 0; p < 5; p++) begin
            if (p > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                drain();
                apply_calibration(phase_cal[p]);
            end
            if (p == 2) begin
                send_idle_pct  = 46;
                recv_stall_pct = 7;
            end else if (p == 4) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            repeat (phase_items[p]) send_touch(random_touch(), 1'b0, '0);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        drain();
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin : watchdog
        #3_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
